>>> rtl/lru_key_value_cache_macros.svh
// ----------------------------------------------------------------------------
// lru_key_value_cache assertion macros
// Shared concurrent assertion forms, clocked by clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LKV_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LKV_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg
// Types, codes and default sizes shared by the LRU key/value cache.
// ----------------------------------------------------------------------------
package lkv_pkg;

	localparam int ENTRIES_DEF    = 16;
	localparam int KEY_BITS_DEF   = 32;
	localparam int VALUE_BITS_DEF = 32;

	// Operation codes
	localparam int MODE_W = 2;
	localparam logic [MODE_W-1:0] MODE_GET   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_PUT   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;
	localparam logic [MODE_W-1:0] MODE_NOP   = 2'd3;

	// Register file
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_REG_LSB = 2;
	localparam logic [CFG_ADDR_W-1-CFG_REG_LSB:0] REG_ENTRY_LIMIT = 1'b0;
	localparam int LIMIT_W = 5;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_FETCH,
		ST_DONE
	} state_t;

	// Commands to the recency tracker
	typedef struct packed {
		logic clear;
		logic promote;
		logic insert;
		logic evict;
	} rcy_cmd_t;

endpackage

>>> rtl/lkv_ram.sv
// ----------------------------------------------------------------------------
// lkv_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lkv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/lkv_recency.sv
// ----------------------------------------------------------------------------
// lkv_recency
// Valid bits, recency ranks and occupancy of the cache slots.
// ----------------------------------------------------------------------------
`include "lru_key_value_cache_macros.svh"

module lkv_recency #(
	parameter int ENTRIES = lkv_pkg::ENTRIES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lkv_pkg::rcy_cmd_t            cmd,
	input  logic [$clog2(ENTRIES)-1:0]   slot,
	input  logic [$clog2(ENTRIES)-1:0]   evict_slot,
	input  logic [$clog2(ENTRIES)-1:0]   probe_idx,
	output logic                         probe_valid,
	output logic                         probe_lru,
	output logic [$clog2(ENTRIES+1)-1:0] occ_count
);
	import lkv_pkg::*;

	localparam int IDX_W  = $clog2(ENTRIES);
	localparam int CNT_W  = $clog2(ENTRIES+1);
	localparam int RANK_W = IDX_W;

	logic [ENTRIES-1:0] valid_q;
	logic [RANK_W-1:0]  rank_q [ENTRIES];
	logic [CNT_W-1:0]   count_q;
	logic [RANK_W-1:0]  lim_rank;
	logic [RANK_W-1:0]  oldest_rank;

	assign lim_rank    = rank_q[slot];
	assign oldest_rank = RANK_W'(count_q - 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else if (cmd.clear) begin
			valid_q <= '0;
			count_q <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else if (cmd.promote) begin
			// age every entry newer than the promoted one
			for (int i = 0; i < ENTRIES; i++) begin
				if (valid_q[i] && IDX_W'(i) != slot && rank_q[i] < lim_rank) begin
					rank_q[i] <= rank_q[i] + 1'b1;
				end
			end
			rank_q[slot] <= '0;
		end else if (cmd.insert) begin
			// age every surviving entry, drop the victim, place the new one
			for (int i = 0; i < ENTRIES; i++) begin
				if (valid_q[i] && IDX_W'(i) != slot &&
						!(cmd.evict && IDX_W'(i) == evict_slot)) begin
					rank_q[i] <= rank_q[i] + 1'b1;
				end
			end
			if (cmd.evict) begin
				valid_q[evict_slot] <= 1'b0;
			end
			valid_q[slot] <= 1'b1;
			rank_q[slot]  <= '0;
			if (!cmd.evict) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	assign probe_valid = valid_q[probe_idx];
	assign probe_lru   = valid_q[probe_idx] && (rank_q[probe_idx] == oldest_rank);
	assign occ_count   = count_q;

	`LKV_ASSERT_NOW(a_count_matches_valid, 1'b1, $countones(valid_q) == int'(count_q), "occupancy differs from valid bits")
	`LKV_ASSERT_NOW(a_one_command, 1'b1, $onehot0({cmd.clear, cmd.promote, cmd.insert}), "conflicting recency commands")
	`LKV_ASSERT_NEXT(a_promoted_newest, cmd.promote && !cmd.clear, rank_q[$past(slot)] == '0, "promoted slot not newest")

endmodule

>>> rtl/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key/value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one operation per transfer:
//   mode get, put or clear, with lookup_key and store_value. Output channel
//   (out_valid / out_stall) returns exactly one result transfer per input:
//   hit, read_value and the eviction report of a put.
//   A get or put walks every slot through one shared key comparator, one
//   slot per cycle, reading the key RAM; a get hit or an evicting put then
//   adds a fetch step. Clear and the unused mode skip the scan. The scan
//   over the key RAM is the longest step of an operation.
//   in_stall is low only while the sequencer is idle; a finished result
//   sits in the output register, so a new item is taken while it waits.
//   If the receiver stalls, the result holds and the next finished item
//   waits in its last step until the output register frees up.
//   Reset empties the cache and sets entry_limit to 16; slot data needs no
//   sweep as valid bits in flops qualify it. The user must write entry_limit
//   (address 0) over the APB port only while idle; the block has no check.
// ----------------------------------------------------------------------------
`include "lru_key_value_cache_macros.svh"

module lru_key_value_cache #(
	parameter int ENTRIES    = lkv_pkg::ENTRIES_DEF,
	parameter int KEY_BITS   = lkv_pkg::KEY_BITS_DEF,
	parameter int VALUE_BITS = lkv_pkg::VALUE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [lkv_pkg::CFG_ADDR_W-1:0]  paddr,
	input  logic [lkv_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic [lkv_pkg::CFG_DATA_W-1:0]  prdata,
	output logic                            pready,
	// operations
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [lkv_pkg::MODE_W-1:0]      mode,
	input  logic [KEY_BITS-1:0]             lookup_key,
	input  logic [VALUE_BITS-1:0]           store_value,
	// results
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            hit,
	output logic [VALUE_BITS-1:0]           read_value,
	output logic                            evicted_valid,
	output logic [KEY_BITS-1:0]             evicted_key,
	output logic [VALUE_BITS-1:0]           evicted_value
);
	import lkv_pkg::*;

	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES+1);
	localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

	// Sequencer and control state
	state_t             state_q, state_nxt;
	logic [CNT_W-1:0]   cnt_q;
	logic               pend_q;
	logic               hit_found_q, lru_found_q, free_found_q;
	logic               out_valid_q;
	logic [LIMIT_W-1:0] limit_q;

	// Captured operation and scan results
	logic [MODE_W-1:0]     mode_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] value_q;
	logic [IDX_W-1:0]      pidx_q;
	logic [IDX_W-1:0]      hit_slot_q, lru_slot_q, free_slot_q, target_q;

	// Staged result and output register
	logic                  res_hit_q, res_ev_valid_q;
	logic [VALUE_BITS-1:0] res_read_q, res_ev_value_q;
	logic [KEY_BITS-1:0]   res_ev_key_q;
	logic                  hit_q, ev_valid_q;
	logic [VALUE_BITS-1:0] read_q, ev_value_q;
	logic [KEY_BITS-1:0]   ev_key_q;

	// RAM and recency interface
	logic                  key_we, val_we;
	logic [IDX_W-1:0]      waddr, raddr;
	logic [KEY_BITS-1:0]   key_rdata;
	logic [VALUE_BITS-1:0] val_rdata;
	rcy_cmd_t              rcy_cmd;
	logic [IDX_W-1:0]      rcy_slot;
	logic                  probe_valid, probe_lru;
	logic [CNT_W-1:0]      occ_count;

	// Derived control
	logic             accept, out_free, load_out;
	logic             is_get, is_put, is_scan_op;
	logic             scan_issue, scan_last;
	logic             scan_match, scan_free, scan_lru;
	logic             at_limit;
	logic [IDX_W-1:0] evict_target;
	logic             cfg_write;
	logic [CMP_W-1:0] count_cw, limit_cw;

	assign accept     = in_valid && !in_stall;
	assign out_free   = !out_valid_q || !out_stall;
	assign load_out   = (state_q == ST_DONE) && out_free;
	assign is_get     = (mode_q == MODE_GET);
	assign is_put     = (mode_q == MODE_PUT);
	assign is_scan_op = (mode == MODE_GET) || (mode == MODE_PUT);

	// One slot per cycle: issue a key read, compare it the cycle after
	assign scan_issue = (cnt_q != CNT_W'(ENTRIES));
	assign scan_last  = pend_q && !scan_issue;
	assign scan_match = pend_q && probe_valid && (key_rdata == key_q);
	assign scan_free  = pend_q && !probe_valid;
	assign scan_lru   = pend_q && probe_lru;

	// Effective limit: zero acts as one, anything above ENTRIES as ENTRIES
	assign count_cw = CMP_W'(occ_count);
	assign limit_cw = CMP_W'(limit_q);
	always_comb begin
		if (limit_q == '0) begin
			at_limit = (occ_count != '0);
		end else if (limit_cw > CMP_W'(ENTRIES)) begin
			at_limit = (count_cw >= CMP_W'(ENTRIES));
		end else begin
			at_limit = (count_cw >= limit_cw);
		end
	end

	// Evicting put: new entry takes the lower of the free and victim slots
	assign evict_target = (free_found_q && (free_slot_q < lru_slot_q)) ? free_slot_q : lru_slot_q;

	// Configuration port
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready &&
		(paddr[CFG_ADDR_W-1:CFG_REG_LSB] == REG_ENTRY_LIMIT);
	assign prdata    = (paddr[CFG_ADDR_W-1:CFG_REG_LSB] == REG_ENTRY_LIMIT) ?
		CFG_DATA_W'(limit_q) : '0;

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_nxt = is_scan_op ? ST_SCAN : ST_DONE;
				end
			end
			ST_SCAN: begin
				if (scan_last) begin
					state_nxt = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if ((is_get && hit_found_q) || (is_put && !hit_found_q && at_limit)) begin
					state_nxt = ST_FETCH;
				end else begin
					state_nxt = ST_DONE;
				end
			end
			ST_FETCH: begin
				state_nxt = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs: RAM ports and recency commands
	always_comb begin
		in_stall = (state_q != ST_IDLE);
		key_we   = 1'b0;
		val_we   = 1'b0;
		waddr    = free_slot_q;
		raddr    = cnt_q[IDX_W-1:0];
		rcy_cmd  = '0;
		rcy_slot = hit_slot_q;
		case (state_q)
			ST_IDLE: begin
				rcy_cmd.clear = accept && (mode == MODE_CLEAR);
			end
			ST_SCAN: begin
				raddr = cnt_q[IDX_W-1:0];
			end
			ST_DECIDE: begin
				if (is_get) begin
					raddr = hit_slot_q;
				end else if (is_put && hit_found_q) begin
					// overwrite in place and make newest
					val_we          = 1'b1;
					waddr           = hit_slot_q;
					rcy_cmd.promote = 1'b1;
					rcy_slot        = hit_slot_q;
				end else if (is_put && at_limit) begin
					raddr = lru_slot_q;
				end else if (is_put) begin
					key_we         = 1'b1;
					val_we         = 1'b1;
					waddr          = free_slot_q;
					rcy_cmd.insert = 1'b1;
					rcy_slot       = free_slot_q;
				end
			end
			ST_FETCH: begin
				if (is_get) begin
					rcy_cmd.promote = 1'b1;
					rcy_slot        = hit_slot_q;
				end else begin
					key_we         = 1'b1;
					val_we         = 1'b1;
					waddr          = target_q;
					rcy_cmd.insert = 1'b1;
					rcy_cmd.evict  = 1'b1;
					rcy_slot       = target_q;
				end
			end
			default: begin
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			pend_q       <= 1'b0;
			hit_found_q  <= 1'b0;
			lru_found_q  <= 1'b0;
			free_found_q <= 1'b0;
			out_valid_q  <= 1'b0;
			limit_q      <= LIMIT_RESET;
		end else begin
			state_q <= state_nxt;
			if (cfg_write) begin
				limit_q <= pwdata[LIMIT_W-1:0];
			end
			if (accept) begin
				cnt_q        <= '0;
				pend_q       <= 1'b0;
				hit_found_q  <= 1'b0;
				lru_found_q  <= 1'b0;
				free_found_q <= 1'b0;
			end else if (state_q == ST_SCAN) begin
				pend_q <= scan_issue;
				if (scan_issue) begin
					cnt_q <= cnt_q + 1'b1;
				end
				if (scan_match) begin
					hit_found_q <= 1'b1;
				end
				if (scan_free) begin
					free_found_q <= 1'b1;
				end
				if (scan_lru) begin
					lru_found_q <= 1'b1;
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q         <= mode;
			key_q          <= lookup_key;
			value_q        <= store_value;
			res_hit_q      <= 1'b0;
			res_read_q     <= '0;
			res_ev_valid_q <= 1'b0;
			res_ev_key_q   <= '0;
			res_ev_value_q <= '0;
		end
		if (state_q == ST_SCAN) begin
			pidx_q <= cnt_q[IDX_W-1:0];
			// keep the first match and the lowest free slot
			if (scan_match && !hit_found_q) begin
				hit_slot_q <= pidx_q;
			end
			if (scan_free && !free_found_q) begin
				free_slot_q <= pidx_q;
			end
			if (scan_lru) begin
				lru_slot_q <= pidx_q;
			end
		end
		if (state_q == ST_DECIDE) begin
			res_hit_q <= hit_found_q;
			target_q  <= evict_target;
		end
		if (state_q == ST_FETCH) begin
			if (is_get) begin
				res_read_q <= val_rdata;
			end else begin
				res_ev_valid_q <= 1'b1;
				res_ev_key_q   <= key_rdata;
				res_ev_value_q <= val_rdata;
			end
		end
		if (load_out) begin
			hit_q      <= res_hit_q;
			read_q     <= res_read_q;
			ev_valid_q <= res_ev_valid_q;
			ev_key_q   <= res_ev_key_q;
			ev_value_q <= res_ev_value_q;
		end
	end

	// Store data goes in with the key; a put hit only writes the value RAM
	lkv_ram #(
		.WIDTH(KEY_BITS),
		.DEPTH(ENTRIES)
	) u_key_ram (
		.clk  (clk),
		.we   (key_we),
		.waddr(waddr),
		.wdata(key_q),
		.raddr(raddr),
		.rdata(key_rdata)
	);

	lkv_ram #(
		.WIDTH(VALUE_BITS),
		.DEPTH(ENTRIES)
	) u_val_ram (
		.clk  (clk),
		.we   (val_we),
		.waddr(waddr),
		.wdata(value_q),
		.raddr(raddr),
		.rdata(val_rdata)
	);

	lkv_recency #(
		.ENTRIES(ENTRIES)
	) u_recency (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (rcy_cmd),
		.slot       (rcy_slot),
		.evict_slot (lru_slot_q),
		.probe_idx  (pidx_q),
		.probe_valid(probe_valid),
		.probe_lru  (probe_lru),
		.occ_count  (occ_count)
	);

	assign out_valid     = out_valid_q;
	assign hit           = hit_q;
	assign read_value    = read_q;
	assign evicted_valid = ev_valid_q;
	assign evicted_key   = ev_key_q;
	assign evicted_value = ev_value_q;

	`LKV_ASSERT_NOW(a_evict_not_hit, out_valid_q && ev_valid_q, !hit_q, "eviction reported on a hit")
	`LKV_ASSERT_NOW(a_free_slot_found, state_q == ST_DECIDE && is_put && !hit_found_q && !at_limit, free_found_q, "no free slot below limit")
	`LKV_ASSERT_NOW(a_victim_found, state_q == ST_DECIDE && is_put && !hit_found_q && at_limit, lru_found_q, "no victim at limit")
	`LKV_ASSERT_NEXT(a_result_loaded, load_out, out_valid_q, "finished result not presented")

endmodule

>>> dv/lru_key_value_cache_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_tb
// Drives get, put, clear and unused operations into the LRU key/value cache
// under several entry limits and checks every result, field by field,
// against an in-bench cache predictor updated on each accepted transfer.
// ----------------------------------------------------------------------------
module lru_key_value_cache_tb;

	import lkv_pkg::*;

	localparam int SLOTS = ENTRIES_DEF;
	localparam int KEY_W = KEY_BITS_DEF;
	localparam int VAL_W = VALUE_BITS_DEF;
	localparam logic [CFG_ADDR_W-1:0] LIMIT_ADDR = {REG_ENTRY_LIMIT, {CFG_REG_LSB{1'b0}}};

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [KEY_W-1:0]  key;
		logic [VAL_W-1:0]  value;
	} cache_op_t;

	typedef struct packed {
		logic             hit;
		logic [VAL_W-1:0] read_value;
		logic             evicted;
		logic [KEY_W-1:0] ev_key;
		logic [VAL_W-1:0] ev_value;
	} cache_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [CFG_DATA_W-1:0] pwdata = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic pready;

	logic in_valid = 1'b0;
	logic in_stall;
	logic [MODE_W-1:0] mode = MODE_GET;
	logic [KEY_W-1:0] lookup_key = '0;
	logic [VAL_W-1:0] store_value = '0;

	logic out_valid;
	logic out_stall = 1'b0;
	logic hit;
	logic [VAL_W-1:0] read_value;
	logic evicted_valid;
	logic [KEY_W-1:0] evicted_key;
	logic [VAL_W-1:0] evicted_value;

	// Pending operations (filled by the sequence) and predicted results
	cache_op_t op_queue[$];
	cache_result_t result_queue[$];
	cache_op_t next_op;
	cache_result_t want;
	logic op_taken = 1'b0;
	int gap_pct = 18;
	int mismatch_count = 0;

	// Predictor state: one line per slot
	logic [KEY_W-1:0] line_key[SLOTS];
	logic [VAL_W-1:0] line_data[SLOTS];
	bit line_live[SLOTS];
	int line_age[SLOTS];
	int live_count;
	logic [LIMIT_W-1:0] entry_cap;

	lru_key_value_cache DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.lookup_key(lookup_key),
		.store_value(store_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.hit(hit),
		.read_value(read_value),
		.evicted_valid(evicted_valid),
		.evicted_key(evicted_key),
		.evicted_value(evicted_value)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Make slot s the most recent: every live line newer than bound ages by one.
	function automatic void age_to_front(int s, int bound);
		for (int i = 0; i < SLOTS; i++)
			if (line_live[i] && i != s && line_age[i] < bound)
				line_age[i]++;
		line_age[s] = 0;
	endfunction

	// Apply one operation to the predictor and return the result it produces.
	function automatic cache_result_t predict_access(cache_op_t op);
		cache_result_t res;
		int found;
		int victim;
		int target;
		int cap;
		res = '0;
		found = -1;
		for (int i = 0; i < SLOTS; i++)
			if (found < 0 && line_live[i] && line_key[i] == op.key)
				found = i;
		case (op.mode)
			MODE_GET: begin
				if (found >= 0) begin
					res.hit = 1'b1;
					res.read_value = line_data[found];
					age_to_front(found, line_age[found]);
				end
			end
			MODE_PUT: begin
				if (found >= 0) begin
					// Overwrite in place; the old value is not reported
					res.hit = 1'b1;
					line_data[found] = op.value;
					age_to_front(found, line_age[found]);
				end else begin
					// Limit 0 behaves as 1, anything above the slot count as full size
					cap = (entry_cap == 0) ? 1 : (entry_cap > SLOTS) ? SLOTS : int'(entry_cap);
					if (live_count >= cap) begin
						victim = -1;
						for (int i = 0; i < SLOTS; i++)
							if (line_live[i] && (victim < 0 || line_age[i] > line_age[victim]))
								victim = i;
						if (victim >= 0) begin
							res.evicted = 1'b1;
							res.ev_key = line_key[victim];
							res.ev_value = line_data[victim];
							line_live[victim] = 1'b0;
							live_count--;
						end
					end
					// Lowest free slot takes the new key
					target = -1;
					for (int i = 0; i < SLOTS; i++)
						if (target < 0 && !line_live[i])
							target = i;
					if (target >= 0) begin
						line_key[target] = op.key;
						line_data[target] = op.value;
						line_live[target] = 1'b1;
						live_count++;
						age_to_front(target, SLOTS);
					end
				end
			end
			MODE_CLEAR: begin
				for (int i = 0; i < SLOTS; i++) begin
					line_live[i] = 1'b0;
					line_age[i] = 0;
				end
				live_count = 0;
			end
			default: ;
		endcase
		return res;
	endfunction

	task automatic check_field(string field, logic [31:0] exp_val, logic [31:0] got_val);
		if (exp_val !== got_val) begin
			$display("%0t ns: %s expected %h actual %h", $time, field, exp_val, got_val);
			mismatch_count++;
		end
	endtask

	// Driver: present the next operation at the falling edge, hold it while
	// stalled, and draw random gaps on both channels.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || op_taken) begin
			if (op_queue.size() != 0 && $urandom_range(99) >= gap_pct) begin
				next_op = op_queue.pop_front();
				in_valid <= 1'b1;
				mode <= next_op.mode;
				lookup_key <= next_op.key;
				store_value <= next_op.value;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_stall <= ($urandom_range(99) < gap_pct);
	end

	// Monitor: track register writes, check each result transfer against the
	// oldest prediction, then predict for the operation transfer on this edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_taken <= 1'b0;
			for (int i = 0; i < SLOTS; i++) begin
				line_key[i] = '0;
				line_data[i] = '0;
				line_live[i] = 1'b0;
				line_age[i] = 0;
			end
			live_count = 0;
			entry_cap = LIMIT_RESET;
		end else begin
			op_taken <= in_valid && !in_stall;
			if (psel && penable && pwrite && pready
					&& paddr[CFG_ADDR_W-1:CFG_REG_LSB] == REG_ENTRY_LIMIT)
				entry_cap = pwdata[LIMIT_W-1:0];
			if (out_valid && !out_stall) begin
				if (result_queue.size() == 0) begin
					$display("%0t ns: result with none pending, expected nothing actual %b %h %b %h %h",
						$time, hit, read_value, evicted_valid, evicted_key, evicted_value);
					mismatch_count++;
				end else begin
					want = result_queue.pop_front();
					check_field("hit", 32'(want.hit), 32'(hit));
					check_field("read_value", want.read_value, read_value);
					check_field("evicted_valid", 32'(want.evicted), 32'(evicted_valid));
					check_field("evicted_key", want.ev_key, evicted_key);
					check_field("evicted_value", want.ev_value, evicted_value);
				end
			end
			if (in_valid && !in_stall)
				result_queue.push_back(predict_access('{mode, lookup_key, store_value}));
		end
	end

	task automatic queue_op(logic [MODE_W-1:0] op_mode, logic [KEY_W-1:0] key,
			logic [VAL_W-1:0] value);
		op_queue.push_back('{op_mode, key, value});
	endtask

	// Hold until the sender has nothing left and every result has come back.
	task automatic await_idle();
		while (op_queue.size() != 0 || in_valid || result_queue.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Setup cycle, then access cycle; the write lands when pready is seen high.
	task automatic write_limit(logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= LIMIT_ADDR;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Random traffic over a small key pool so gets hit and puts evict; a tenth
	// of the keys are fresh noise, a few operations are clears or unused mode.
	task automatic queue_burst(int count, int pool_size);
		logic [KEY_W-1:0] key_pool[$];
		logic [MODE_W-1:0] op_mode;
		logic [KEY_W-1:0] op_key;
		int pick;
		for (int i = 0; i < pool_size; i++)
			key_pool.push_back($urandom);
		key_pool[0] = '0;
		key_pool[1] = '1;
		repeat (count) begin
			pick = $urandom_range(99);
			if (pick < 2)
				op_mode = MODE_CLEAR;
			else if (pick < 4)
				op_mode = MODE_NOP;
			else if (pick < 50)
				op_mode = MODE_GET;
			else
				op_mode = MODE_PUT;
			op_key = ($urandom_range(9) == 0) ? KEY_W'($urandom)
				: key_pool[$urandom_range(pool_size - 1)];
			queue_op(op_mode, op_key, $urandom);
		end
	endtask

	initial begin
		int lim;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset limit: miss on empty, insert, get hit, put hit, unused mode, clear
		queue_op(MODE_GET, '0, '1);
		queue_op(MODE_PUT, '0, '1);
		queue_op(MODE_GET, '0, '0);
		queue_op(MODE_PUT, '1, '0);
		queue_op(MODE_PUT, '0, 32'hA5A5_A5A5);
		queue_op(MODE_GET, '1, '1);
		queue_op(MODE_GET, '0, '0);
		queue_op(MODE_NOP, '0, '1);
		queue_op(MODE_GET, 32'h0001_2345, '0);
		queue_op(MODE_CLEAR, '1, '1);
		queue_op(MODE_GET, '0, '0);
		await_idle();

		// Single entry: every new key evicts the previous one
		write_limit(32'd1);
		queue_op(MODE_PUT, 32'd1, 32'h11);
		queue_op(MODE_PUT, 32'd2, 32'h22);
		queue_op(MODE_GET, 32'd1, '0);
		queue_op(MODE_GET, 32'd2, '0);
		queue_op(MODE_PUT, 32'd2, 32'h33);
		queue_burst(60, 4);
		await_idle();

		// Zero limit (upper bits set, dropped by the register) acts as one
		write_limit(32'hFFFF_FFE0);
		queue_op(MODE_PUT, 32'd3, 32'h5555_5555);
		queue_op(MODE_GET, 32'd2, '0);
		queue_burst(50, 3);
		await_idle();

		// Above the slot count acts as full size; run this stretch with no gaps
		write_limit(32'd31);
		gap_pct = 0;
		queue_burst(120, 24);
		await_idle();
		gap_pct = 18;

		// Fill every slot, then lower the limit below the occupancy
		write_limit(32'd16);
		queue_op(MODE_CLEAR, '0, '0);
		for (int i = 0; i < SLOTS; i++)
			queue_op(MODE_PUT, 32'h8000_0000 | i, $urandom);
		queue_burst(150, 24);
		await_idle();
		write_limit(32'd3);
		for (int i = 0; i < SLOTS; i += 3)
			queue_op(MODE_GET, 32'h8000_0000 | i, '0);
		for (int i = 0; i < 4; i++)
			queue_op(MODE_PUT, 32'h4000_0000 | i, $urandom);
		queue_burst(100, 20);
		await_idle();

		// Middle limits, each a separate phase with the sender held until drained
		repeat (3) begin
			lim = $urandom_range(2, 15);
			write_limit({27'($urandom), LIMIT_W'(lim)});
			queue_burst(90, lim + lim / 2 + 2);
			await_idle();
		end

		write_limit(32'd16);
		queue_burst(155, 40);
		await_idle();

		// Allow for any late or surplus result before judging
		repeat (40) @(posedge clk);
		mismatch_count += result_queue.size();
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
